@@ rtl/tcss_pkg.sv @@
`default_nettype none

package tcss_pkg;

    localparam int unsigned CodeW  = 8;
    localparam int unsigned WordW  = 16;
    localparam int unsigned CmdW   = 3;
    localparam int unsigned BitCntW = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CodeW-1:0] XCodeRst     = 8'd144;
    localparam logic [CodeW-1:0] YCodeRst     = 8'd208;
    localparam logic [CodeW-1:0] Z1CodeRst    = 8'd176;
    localparam logic [WordW-1:0] PressureRst  = 16'd16;

    localparam logic [BitCntW-1:0] LastBit    = 3'd7;
    localparam logic [1:0]         ByteCntMax = 2'd3;

    typedef enum logic [1:0] {
        CH_NONE = 2'd0,
        CH_X    = 2'd1,
        CH_Y    = 2'd2,
        CH_Z1   = 2'd3
    } channel_t;

    typedef enum logic [CmdW-1:0] {
        CMD_CLK_FALL = 3'd0,
        CMD_MOSI     = 3'd1,
        CMD_SEL_RISE = 3'd2,
        CMD_TOUCH    = 3'd3
    } cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_X_CODE   = 2'd0,
        REG_Y_CODE   = 2'd1,
        REG_Z1_CODE  = 2'd2,
        REG_PRESSURE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CodeW-1:0] x_code;
        logic [CodeW-1:0] y_code;
        logic [CodeW-1:0] z1_code;
        logic [WordW-1:0] pressure;
    } cfg_t;

    typedef struct packed {
        logic [CmdW-1:0]  command;
        logic             mosi_bit;
        logic             select_level;
        logic [WordW-1:0] touch_x;
        logic [WordW-1:0] touch_y;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/tcss_cfg.sv @@
`default_nettype none

module tcss_cfg
    import tcss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_addr,
    input  wire logic [WordW-1:0]   cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_X_CODE:   cfg_next.x_code   = cfg_wdata[CodeW-1:0];
                REG_Y_CODE:   cfg_next.y_code   = cfg_wdata[CodeW-1:0];
                REG_Z1_CODE:  cfg_next.z1_code  = cfg_wdata[CodeW-1:0];
                REG_PRESSURE: cfg_next.pressure = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_code   <= XCodeRst;
            cfg_reg.y_code   <= YCodeRst;
            cfg_reg.z1_code  <= Z1CodeRst;
            cfg_reg.pressure <= PressureRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/tcss_core.sv @@
`default_nettype none

module tcss_core
    import tcss_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  item_t     item,
    input  cfg_t      cfg,
    output logic      miso_next
);

    channel_t           channel_reg, channel_next;
    logic [CodeW-1:0]   shift_reg, shift_next;
    logic [BitCntW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [1:0]         byte_cnt_reg, byte_cnt_next;
    logic [WordW-1:0]   x_reg, x_next;
    logic [WordW-1:0]   y_reg, y_next;
    logic               pending_reg, pending_next;
    logic               miso_reg;

    // bit select: byte 0 -> bits 15..8, byte 1 -> bits 7..0, else 0
    function automatic logic pick_bit(input logic [WordW-1:0] word,
                                      input logic [1:0] byte_cnt,
                                      input logic [BitCntW-1:0] bit_cnt);
        logic r;
        r = 1'b0;
        if (byte_cnt == 2'd0)
            r = word[{1'b1, ~bit_cnt}];
        else if (byte_cnt == 2'd1)
            r = word[{1'b0, ~bit_cnt}];
        return r;
    endfunction

    logic selected;
    logic z1_live;
    logic [CodeW-1:0] shifted;

    assign selected = !item.select_level;
    assign z1_live  = (channel_reg == CH_Z1) && pending_reg;
    assign shifted  = {shift_reg[CodeW-2:0], item.mosi_bit};

    always_comb begin
        channel_next  = channel_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pending_next  = pending_reg;
        miso_next     = miso_reg;
        case (item.command)
            CMD_MOSI: begin
                if (selected) begin
                    if (channel_reg == CH_X) begin
                        miso_next = pick_bit(x_reg, byte_cnt_reg, bit_cnt_reg);
                    end else if (channel_reg == CH_Y) begin
                        miso_next    = pick_bit(y_reg, byte_cnt_reg, bit_cnt_reg);
                        pending_next = 1'b0;
                    end else if (z1_live) begin
                        miso_next = pick_bit(cfg.pressure, byte_cnt_reg, bit_cnt_reg);
                    end else begin
                        miso_next = 1'b0;
                    end
                    if (z1_live && byte_cnt_reg == ByteCntMax)
                        channel_next = CH_NONE;
                end
            end
            CMD_CLK_FALL: begin
                if (selected) begin
                    shift_next = shifted;
                    if (bit_cnt_reg == LastBit) begin
                        bit_cnt_next = '0;
                        if (byte_cnt_reg != ByteCntMax)
                            byte_cnt_next = byte_cnt_reg + 2'd1;
                        // X wins over Y, Y over Z1 on equal codes
                        if (shifted == cfg.x_code) begin
                            channel_next  = CH_X;
                            byte_cnt_next = '0;
                        end else if (shifted == cfg.y_code) begin
                            channel_next  = CH_Y;
                            byte_cnt_next = '0;
                        end else if (shifted == cfg.z1_code) begin
                            channel_next  = CH_Z1;
                            byte_cnt_next = '0;
                        end
                    end else begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                    end
                end
            end
            CMD_SEL_RISE: begin
                channel_next  = CH_NONE;
                shift_next    = '0;
                bit_cnt_next  = '0;
                byte_cnt_next = '0;
            end
            CMD_TOUCH: begin
                x_next       = item.touch_x;
                y_next       = item.touch_y;
                pending_next = 1'b1;
            end
            default: begin
                miso_next = miso_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg  <= CH_NONE;
            shift_reg    <= '0;
            bit_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            pending_reg  <= 1'b0;
            miso_reg     <= 1'b0;
        end else if (fire) begin
            channel_reg  <= channel_next;
            shift_reg    <= shift_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            pending_reg  <= pending_next;
            miso_reg     <= miso_next;
        end
    end

    a_sel_rise_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command == CMD_SEL_RISE |=>
            channel_reg == CH_NONE && bit_cnt_reg == '0 && byte_cnt_reg == '0)
        else $error("select rise did not clear transfer state");

    a_touch_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command == CMD_TOUCH |=> pending_reg)
        else $error("touch did not set pending flag");

    a_bit_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command == CMD_CLK_FALL && !item.select_level
            && bit_cnt_reg != LastBit |=> bit_cnt_reg == $past(bit_cnt_reg) + 3'd1)
        else $error("bit count did not advance");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(channel_reg) && $stable(miso_reg) && $stable(pending_reg))
        else $error("state changed without a transaction");

endmodule

`default_nettype wire

@@ rtl/touch_controller_spi_slave.sv @@
`default_nettype none

// Resistive touch controller, SPI slave side. Each input transaction is one
// pin or touch event (clock fall, MOSI change, chip-select rise, touch); each
// one yields exactly one output transaction carrying the MISO level after
// that event. Throughput is one transaction per clock while the consumer holds
// m_ready high: the event is captured in an input register, then decoded and
// applied to the transfer state in the same cycle that the resulting MISO level
// is written into an output register. The input register frees up whenever
// the output register is empty or being drained, so a stalled consumer only
// holds off new input once both registers are full. Command codes and the Z1
// pressure answer are written through cfg_we/cfg_addr/cfg_wdata; writes take
// effect on the next cycle and should be made while no transaction is in
// flight.
module touch_controller_spi_slave
    import tcss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_addr,
    input  wire logic [WordW-1:0]   cfg_wdata,

    // event input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CmdW-1:0]    s_command,
    input  wire logic               s_mosi_bit,
    input  wire logic               s_select_level,
    input  wire logic [WordW-1:0]   s_touch_x,
    input  wire logic [WordW-1:0]   s_touch_y,

    // MISO result
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_miso_bit
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_vld_reg, in_vld_next;
    logic  out_vld_reg, out_vld_next;
    logic  miso_out_reg;
    logic  miso_next;
    logic  advance;

    tcss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // event moves into the state when the output slot is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (m_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command      <= s_command;
            item_reg.mosi_bit     <= s_mosi_bit;
            item_reg.select_level <= s_select_level;
            item_reg.touch_x      <= s_touch_x;
            item_reg.touch_y      <= s_touch_y;
        end
        if (advance)
            miso_out_reg <= miso_next;
    end

    tcss_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (item_reg),
        .cfg       (cfg),
        .miso_next (miso_next)
    );

    assign m_valid    = out_vld_reg;
    assign m_miso_bit = miso_out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready |=> out_vld_reg)
        else $error("pending result dropped");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("advanced event left no result");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |-> !s_ready)
        else $error("input accepted while both stages full");

endmodule

`default_nettype wire

@@ bench/touch_controller_spi_slave_tb.sv @@
module touch_controller_spi_slave_tb;
    import tcss_pkg::*;

    localparam int ClkHalf      = 6;
    localparam int CycleLimit   = 400000;
    localparam int NumSettings  = 5;
    localparam int PhaseEvents  = 105;
    localparam int SettleCycles = 6;
    localparam int DrainLimit   = 5000;
    localparam int LongHold     = 80;

    // One directed row: the event, and the MISO level where it is obvious by eye.
    typedef struct {
        item_t ev;
        bit    typed;
        logic  miso;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known level
    // ------------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [CfgIdxW-1:0] cfg_addr       = '0;
    logic [WordW-1:0]   cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic [CmdW-1:0]    s_command      = '0;
    logic               s_mosi_bit     = 1'b0;
    logic               s_select_level = 1'b1;
    logic [WordW-1:0]   s_touch_x      = '0;
    logic [WordW-1:0]   s_touch_y      = '0;
    logic               m_ready        = 1'b0;
    wire                s_ready;
    wire                m_valid;
    wire                m_miso_bit;

    touch_controller_spi_slave dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_mosi_bit    (s_mosi_bit),
        .s_select_level(s_select_level),
        .s_touch_x     (s_touch_x),
        .s_touch_y     (s_touch_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_miso_bit    (m_miso_bit)
    );

    // ------------------------------------------------------------------
    // Mirror of the slave: register settings and transfer state
    // ------------------------------------------------------------------
    logic [CodeW-1:0]   code_x   = XCodeRst;
    logic [CodeW-1:0]   code_y   = YCodeRst;
    logic [CodeW-1:0]   code_z1  = Z1CodeRst;
    logic [WordW-1:0]   press    = PressureRst;

    channel_t           chan     = CH_NONE;
    logic [CodeW-1:0]   shreg    = '0;
    logic [BitCntW-1:0] bit_cnt  = '0;
    logic [1:0]         byte_cnt = '0;
    logic [WordW-1:0]   lat_x    = '0;
    logic [WordW-1:0]   lat_y    = '0;
    logic               pend     = 1'b0;
    logic               miso     = 1'b0;

    // MISO levels owed by the DUT, oldest first
    logic     miso_due[$];
    logic     miso_want;
    dir_row_t dir_rows[$];

    int err_cnt     = 0;
    int event_cnt   = 0;
    int result_cnt  = 0;
    int frame_cnt   = 0;
    int y_read_cnt  = 0;
    int z1_drop_cnt = 0;
    int dir_cnt     = 0;
    int cycles      = 0;
    int hold_cnt;

    bit idle_on       = 1'b1;   // random bubbles on both sides
    bit long_hold_req = 1'b0;   // asks the receiver for one long stall

    initial begin
        forever #ClkHalf aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Report / predict helpers
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Bit of a readout word for the current byte/bit position; zero past byte 1.
    function automatic logic word_bit(input logic [WordW-1:0] w);
        case (byte_cnt)
            2'd0:    return w[15 - bit_cnt];
            2'd1:    return w[7 - bit_cnt];
            default: return 1'b0;
        endcase
    endfunction

    // Applies one event to the mirror and returns the MISO level after it.
    function automatic logic next_miso(input item_t ev);
        logic selected;
        logic z1_live;
        selected = !ev.select_level;
        z1_live  = (chan == CH_Z1) && pend;
        if (ev.command == CMD_MOSI && selected) begin
            case (chan)
                CH_X: miso = word_bit(lat_x);
                CH_Y: begin
                    miso = word_bit(lat_y);
                    pend = 1'b0;     // reading Y consumes the touch
                    y_read_cnt++;
                end
                default: miso = z1_live ? word_bit(press) : 1'b0;
            endcase
            // Z1 lets go of the channel once the counter has saturated
            if (z1_live && byte_cnt == ByteCntMax) begin
                chan = CH_NONE;
                z1_drop_cnt++;
            end
        end else if (ev.command == CMD_CLK_FALL && selected) begin
            shreg = {shreg[CodeW-2:0], ev.mosi_bit};
            if (bit_cnt == LastBit) begin
                bit_cnt = '0;
                if (byte_cnt != ByteCntMax)
                    byte_cnt++;
                // X wins over Y, Y over Z1 when codes coincide
                if (shreg == code_x) begin
                    chan     = CH_X;
                    byte_cnt = '0;
                end else if (shreg == code_y) begin
                    chan     = CH_Y;
                    byte_cnt = '0;
                end else if (shreg == code_z1) begin
                    chan     = CH_Z1;
                    byte_cnt = '0;
                end
            end else begin
                bit_cnt++;
            end
        end else if (ev.command == CMD_SEL_RISE) begin
            // select level does not matter here; latches, flag and MISO survive
            chan     = CH_NONE;
            shreg    = '0;
            bit_cnt  = '0;
            byte_cnt = '0;
        end else if (ev.command == CMD_TOUCH) begin
            lat_x = ev.touch_x;
            lat_y = ev.touch_y;
            pend  = 1'b1;
        end
        return miso;
    endfunction

    // Coordinates lean toward the extremes now and then.
    function automatic logic [WordW-1:0] coord_val();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WordW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic item_t mk_ev(input logic [CmdW-1:0] c, input logic mosi,
                                    input logic sel_lvl);
        item_t ev;
        ev.command      = c;
        ev.mosi_bit     = mosi;
        ev.select_level = sel_lvl;
        ev.touch_x      = coord_val();
        ev.touch_y      = coord_val();
        return ev;
    endfunction

    task automatic add_row(input logic [CmdW-1:0] c, input logic mosi, input logic sel_lvl,
                           input logic [WordW-1:0] x, input logic [WordW-1:0] y,
                           input bit typed, input logic want);
        dir_row_t row;
        row.ev.command      = c;
        row.ev.mosi_bit     = mosi;
        row.ev.select_level = sel_lvl;
        row.ev.touch_x      = x;
        row.ev.touch_y      = y;
        row.typed           = typed;
        row.miso            = want;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Event driver. Called at a rising edge; returns at the edge where the
    // transaction is taken, with s_valid still high so back-to-back events
    // never drop valid.
    // ------------------------------------------------------------------
    task automatic send_event(input item_t ev, input bit typed, input logic want);
        logic predicted;
        if (idle_on && !long_hold_req && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= ev.command;
        s_mosi_bit     <= ev.mosi_bit;
        s_select_level <= ev.select_level;
        s_touch_x      <= ev.touch_x;
        s_touch_y      <= ev.touch_y;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predicted = next_miso(ev);
        miso_due.push_back(typed ? want : predicted);
        // only events the slave acts on count toward the run length
        if (ev.command == CMD_SEL_RISE || ev.command == CMD_TOUCH ||
            ((ev.command == CMD_CLK_FALL || ev.command == CMD_MOSI) && !ev.select_level))
            event_cnt++;
    endtask

    // Stop offering, wait out every owed result plus the pipeline, bounded.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (miso_due.size() != 0 && waited < DrainLimit) begin
            @(posedge aclk);
            waited++;
        end
        if (miso_due.size() != 0) begin
            flag_mismatch($sformatf("%0d MISO results never arrived", miso_due.size()));
            miso_due.delete();
        end
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [WordW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CodeW-1:0] x, input logic [CodeW-1:0] y,
                                 input logic [CodeW-1:0] z1, input logic [WordW-1:0] p);
        write_reg(REG_X_CODE, WordW'(x));
        write_reg(REG_Y_CODE, WordW'(y));
        write_reg(REG_Z1_CODE, WordW'(z1));
        write_reg(REG_PRESSURE, p);
        cfg_we  <= 1'b0;
        code_x  = x;
        code_y  = y;
        code_z1 = z1;
        press   = p;
    endtask

    // One chip-select frame: optional touch, a command byte (sometimes cut
    // short), a readout of random length, then usually a select rise.
    task automatic run_frame();
        logic [CodeW-1:0] code;
        int pick;
        int nbits;
        int nread;
        bit is_z1;
        frame_cnt++;
        pick  = $urandom_range(0, 9);
        is_z1 = (pick >= 6 && pick < 9);
        if (pick < 3)
            code = code_x;
        else if (pick < 6)
            code = code_y;
        else if (is_z1)
            code = code_z1;
        else
            code = CodeW'($urandom_range(0, 255));
        // Z1 only answers with a touch pending, so give it one more often
        if ($urandom_range(0, 3) < (is_z1 ? 3 : 2))
            send_event(mk_ev(CMD_TOUCH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                       1'b0, 1'b0);
        nbits = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 7) : 8;
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 1))
                send_event(mk_ev(CMD_MOSI, 1'($urandom_range(0, 1)), 1'b0), 1'b0, 1'b0);
            send_event(mk_ev(CMD_CLK_FALL, code[7 - i], $urandom_range(0, 39) == 0),
                       1'b0, 1'b0);
        end
        if (nbits < 8)
            nread = 0;
        else if ($urandom_range(0, 3) == 0)
            nread = $urandom_range(0, 12);
        else
            nread = $urandom_range(14, 34);   // from 24 reads on, long enough to saturate the byte count
        for (int r = 0; r < nread; r++) begin
            if ($urandom_range(0, 29) == 0)
                send_event(mk_ev(CMD_TOUCH, 1'($urandom_range(0, 1)), 1'b0), 1'b0, 1'b0);
            send_event(mk_ev(CMD_MOSI, 1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0),
                       1'b0, 1'b0);
            send_event(mk_ev(CMD_CLK_FALL, 1'($urandom_range(0, 1)), 1'b0), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 7) != 0)
            send_event(mk_ev(CMD_SEL_RISE, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))), 1'b0, 1'b0);
    endtask

    // Unstructured events, including the unused command values.
    task automatic noise_burst();
        repeat ($urandom_range(1, 8))
            send_event(mk_ev(CmdW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))), 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold on request so the DUT
    // backs up and drops s_ready.
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LongHold; hold_cnt++)
                    @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted MISO transaction against the oldest
    // owed level.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (miso_due.size() == 0) begin
                flag_mismatch("MISO result with nothing expected");
            end else begin
                miso_want = miso_due.pop_front();
                if (m_miso_bit !== miso_want)
                    flag_mismatch($sformatf("result %0d: miso_bit %b, expected %b",
                                            result_cnt, m_miso_bit, miso_want));
            end
        end
    end

    // Watchdog
    initial begin
        for (cycles = 0; cycles < CycleLimit; cycles++)
            @(posedge aclk);
        $display("timeout after %0d cycles", CycleLimit);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [CodeW-1:0] c;
        int target;
        bit mid_drained;

        // Directed table, run under the reset register values.
        add_row(CMD_MOSI, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0);  // nothing selected
        add_row(3'd7, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);      // unused command
        add_row(CMD_TOUCH, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0); // touch, deselected
        for (int b = CodeW - 1; b >= 0; b--)                             // X command byte
            add_row(CMD_CLK_FALL, XCodeRst[b], 1'b0, 16'hA5A5, 16'h5A5A, 1'b0, 1'b0);
        add_row(CMD_MOSI, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);  // X msb
        add_row(CMD_MOSI, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);  // deselected, holds
        add_row(CMD_CLK_FALL, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
        add_row(3'd4, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);      // unused command
        add_row(CMD_SEL_RISE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1); // MISO holds
        add_row(CMD_MOSI, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0);  // channel gone
        add_row(CMD_TOUCH, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        for (int b = CodeW - 1; b >= 0; b--)                             // Y command byte
            add_row(CMD_CLK_FALL, YCodeRst[b], 1'b0, 16'h1234, 16'h8001, 1'b0, 1'b0);
        add_row(CMD_MOSI, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);  // Y msb, clears touch
        add_row(CMD_SEL_RISE, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].miso);
        dir_cnt = event_cnt;

        // Random part across several register settings. Setting 0 keeps
        // the reset values; the rest hit code extremes, equal codes and
        // both ends of the pressure answer.
        for (int ph = 0; ph < NumSettings; ph++) begin
            if (ph > 0) begin
                drain_results();
                c = CodeW'($urandom_range(0, 255));
                case (ph)
                    1: load_settings(8'h00, 8'hFF, 8'h5A, 16'hFFFF);
                    2: load_settings(c, c, c, 16'h0000);
                    3: load_settings(~c, c, c, WordW'($urandom_range(0, 65535)));
                    default: load_settings(CodeW'($urandom_range(0, 255)),
                                           CodeW'($urandom_range(0, 255)),
                                           CodeW'($urandom_range(0, 255)),
                                           WordW'($urandom_range(0, 65535)));
                endcase
            end
            target      = event_cnt + PhaseEvents;
            mid_drained = 1'b0;
            if (ph == 2)
                long_hold_req = 1'b1;
            while (event_cnt < target) begin
                // quiet tail: full-rate traffic on both sides
                if (ph == NumSettings - 1 && event_cnt > target - 60)
                    idle_on = 1'b0;
                // one mid-phase pause until the DUT has caught up
                if (ph == 3 && !mid_drained && event_cnt > target - PhaseEvents / 2) begin
                    drain_results();
                    mid_drained = 1'b1;
                end
                if ($urandom_range(0, 7) == 0)
                    noise_burst();
                else
                    run_frame();
            end
        end

        drain_results();

        $display("Drove %0d directed and %0d random events over %0d register settings.",
                 dir_cnt, event_cnt - dir_cnt, NumSettings);
        $display("Checked %0d MISO results: %0d frames, %0d Y reads, %0d Z1 drops.",
                 result_cnt, frame_cnt, y_read_cnt, z1_drop_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
